// ===== hw/rtl/particle_attract_repel_step_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the attract/repel step block
// ----------------------------------------------------------------------------
`ifndef PARTICLE_ATTRACT_REPEL_STEP_ASSERT_SVH
`define PARTICLE_ATTRACT_REPEL_STEP_ASSERT_SVH

// condition that holds at every edge out of reset
`define PAR_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// condition that holds in the cycle after a trigger
`define PAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/par_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_pkg
// Types and constants shared by the attract/repel step block.
// ----------------------------------------------------------------------------
package par_pkg;

    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned SQRT_STEPS  = 32;
    localparam int unsigned QUO_W       = 34;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONST    = 3'd4;

    // saturation bound of each product term
    localparam logic [61:0] TERM_CAP = 62'h2000_0000_0000_0000;
    // most negative step
    localparam logic signed [63:0] STEP_FLOOR = 64'shFFFF_FFFF_0000_0000;

    typedef struct packed {
        logic [15:0]        particle_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic [31:0]        elapsed_time;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        particle_index_out;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic               moved;
    } t_out_item;

    typedef struct packed {
        logic [30:0]        min_distance;
        logic [30:0]        max_distance;
        logic signed [31:0] quad_coeff;
        logic signed [31:0] lin_coeff;
        logic signed [31:0] const_coeff;
    } t_cfg;

    // classified item between front and back
    typedef struct packed {
        logic [15:0]       idx;
        logic [2:0][31:0]  pos;
        logic [2:0]        dneg;
        logic [2:0][30:0]  mag;
        logic [63:0]       sum;
        logic              in_window;
        logic [31:0]       elapsed;
    } t_work;

endpackage

// ===== hw/rtl/par_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_if
// Valid/ready channels of the attract/repel step block.
// ----------------------------------------------------------------------------
interface par_in_if;
    import par_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface par_out_if;
    import par_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface par_cfg_if;
    import par_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/par_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_front
// Takes particles, forms displacement and squared length, classifies the
// item against the distance window and hands it to the queue.
// ----------------------------------------------------------------------------
module par_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  par_pkg::t_in_item i_item,
    input  par_pkg::t_cfg     i_cfg,
    output logic              o_push,
    input  logic              i_full,
    output par_pkg::t_work    o_work
);
    import par_pkg::*;

    logic             r_v1, r_v2, r_v3;
    t_work            r_s1_w, r_s2_w, r_s3_w;
    logic [61:0]      r_s2_sq [3];
    logic [61:0]      r_min_sq, r_max_sq;
    logic             w_adv1, w_adv2, w_adv3;
    logic [2:0][31:0] w_pos, w_tgt;
    logic [32:0]      w_dl [3];
    logic [32:0]      w_mg [3];
    logic             w_big;
    logic [63:0]      w_sum;
    t_work            n_s1_w;
    t_work            n_s3_w;

    // elastic stage control
    assign w_adv3  = !r_v3 || !i_full;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_push  = r_v3 && !i_full;
    assign o_work  = r_s3_w;

    // displacement and its magnitude
    assign w_pos = {i_item.pos_z, i_item.pos_y, i_item.pos_x};
    assign w_tgt = {i_item.target_z, i_item.target_y, i_item.target_x};

    always_comb begin
        w_big = 1'b0;
        n_s1_w = '0;
        for (int i = 0; i < 3; i++) begin
            w_dl[i] = {w_tgt[i][31], w_tgt[i]} - {w_pos[i][31], w_pos[i]};
            w_mg[i] = w_dl[i][32] ? (33'd0 - w_dl[i]) : w_dl[i];
            w_big   = w_big | w_mg[i][32] | w_mg[i][31];
            n_s1_w.pos[i]  = w_pos[i];
            n_s1_w.dneg[i] = w_dl[i][32];
            n_s1_w.mag[i]  = w_mg[i][30:0];
        end
        n_s1_w.idx       = i_item.particle_index;
        n_s1_w.elapsed   = i_item.elapsed_time;
        n_s1_w.in_window = !w_big;
    end

    // squared length
    assign w_sum = {2'b00, r_s2_sq[0]} + {2'b00, r_s2_sq[1]} + {2'b00, r_s2_sq[2]};

    // window test on the squared length
    always_comb begin
        n_s3_w           = r_s2_w;
        n_s3_w.sum       = w_sum;
        n_s3_w.in_window = r_s2_w.in_window && (w_sum > {2'b00, r_min_sq})
                           && (w_sum < {2'b00, r_max_sq});
    end

    // window bounds squared
    always_ff @(posedge i_clk) begin
        r_min_sq <= i_cfg.min_distance * i_cfg.min_distance;
        r_max_sq <= i_cfg.max_distance * i_cfg.max_distance;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_w <= n_s1_w;
        end
        if (w_adv2) begin
            r_s2_w <= r_s1_w;
            for (int i = 0; i < 3; i++) begin
                r_s2_sq[i] <= r_s1_w.mag[i] * r_s1_w.mag[i];
            end
        end
        if (w_adv3) begin
            r_s3_w <= n_s3_w;
        end
    end

endmodule

// ===== hw/rtl/par_queue.sv =====
`timescale 1ns / 1ps
`include "particle_attract_repel_step_assert.svh"
// ----------------------------------------------------------------------------
// par_queue
// Short register queue between the classifying front and the math back.
// ----------------------------------------------------------------------------
module par_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  par_pkg::t_work i_work,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output par_pkg::t_work o_work
);
    import par_pkg::*;

    t_work            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_work  = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop) r_rptr <= r_rptr + 1'b1;
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= i_work;
    end

    `PAR_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH))
    `PAR_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1)
    `PAR_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n, w_pop && !w_push && r_count == 1, o_empty)

endmodule

// ===== hw/rtl/par_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_back
// Root, step polynomial, clamp, per-axis divide and saturating update,
// as one stall-together pipeline ending in an output register.
// ----------------------------------------------------------------------------
module par_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  par_pkg::t_work     i_work,
    input  par_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output par_pkg::t_out_item o_item
);
    import par_pkg::*;

    typedef struct packed {
        t_work       w;
        logic [31:0] d;
    } t_carry;

    logic w_en;

    // static coefficient magnitudes
    logic        r_qneg, r_lneg;
    logic [31:0] r_qm, r_lm;

    // root stages
    logic [SQRT_STEPS:0] r_sq_v;
    t_work               r_sq_w    [SQRT_STEPS+1];
    logic [35:0]         r_sq_rem  [SQRT_STEPS+1];
    logic [31:0]         r_sq_root [SQRT_STEPS+1];
    logic [63:0]         r_sq_rad  [SQRT_STEPS+1];
    logic [35:0]         w_sq_sh   [SQRT_STEPS];
    logic                w_sq_ge   [SQRT_STEPS];

    // polynomial stages
    logic        r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v, r_p6_v;
    t_carry      r_p1_c, r_p2_c, r_p3_c, r_p4_c, r_p5_c, r_p6_c;
    logic [63:0] r_p1_ql, r_p1_qh, r_p1_l;
    logic [63:0] r_p2_tq, r_p2_tl, r_p3_poly;
    logic        r_p4_pneg;
    logic [63:0] r_p4_lo, r_p4_hi, r_p5_t;
    logic [32:0] r_p6_tm;
    logic        r_p6_tneg;
    logic [63:0] w_d2;
    logic [95:0] w_pq, w_pq_s, w_pe, w_pe_s;
    logic [63:0] w_pl_s, w_tq, w_tl, w_pm, w_t;
    logic [61:0] w_tq_m, w_tl_m, w_t_m;
    logic signed [63:0] w_ts, w_dd, w_tc;
    logic [63:0] w_tc_abs;

    // product and divide stages
    logic        r_d0_v;
    t_carry      r_d0_c;
    logic [63:0] r_d0_n [3];
    logic        r_d0_tneg;
    logic [QUO_W:0] r_dv_v;
    t_carry      r_dv_c    [QUO_W+1];
    logic        r_dv_tneg [QUO_W+1];
    logic [2:0]  r_dv_ovf  [QUO_W+1];
    logic [31:0] r_dv_rem  [QUO_W+1][3];
    logic [QUO_W-1:0] r_dv_num [QUO_W+1][3];
    logic [QUO_W-1:0] r_dv_q   [QUO_W+1][3];
    logic [32:0] w_dv_sh [QUO_W][3];
    logic        w_dv_ge [QUO_W][3];
    logic [2:0]  w_dv_ovf0;

    // final update
    logic        r_out_v;
    t_out_item   r_out;
    t_carry      w_fc;
    logic [QUO_W-1:0] w_m [3];
    logic [35:0] w_mv [3];
    logic [35:0] w_s36 [3];
    logic [31:0] w_nv [3];
    logic        w_moved;
    t_out_item   n_out;

    assign w_en    = !r_out_v || i_ready;
    assign o_pop   = w_en && i_valid;
    assign o_valid = r_out_v;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        r_qneg <= i_cfg.quad_coeff[31];
        r_lneg <= i_cfg.lin_coeff[31];
        r_qm   <= i_cfg.quad_coeff[31] ? (32'd0 - i_cfg.quad_coeff) : i_cfg.quad_coeff;
        r_lm   <= i_cfg.lin_coeff[31] ? (32'd0 - i_cfg.lin_coeff) : i_cfg.lin_coeff;
    end

    // one root bit per stage
    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            w_sq_sh[k] = {r_sq_rem[k][33:0], r_sq_rad[k][63:62]};
            w_sq_ge[k] = w_sq_sh[k] >= {2'b00, r_sq_root[k], 2'b01};
        end
    end

    // polynomial terms
    always_comb begin
        w_d2   = r_sq_w[SQRT_STEPS].sum >> FRAC_BITS;
        w_pq   = {32'd0, r_p1_ql} + {r_p1_qh, 32'd0};
        w_pq_s = w_pq >> FRAC_BITS;
        w_tq_m = (w_pq_s > {34'd0, TERM_CAP}) ? TERM_CAP : w_pq_s[61:0];
        w_pl_s = r_p1_l >> FRAC_BITS;
        w_tl_m = (w_pl_s > {2'b00, TERM_CAP}) ? TERM_CAP : w_pl_s[61:0];
        w_tq   = {2'b00, w_tq_m};
        w_tl   = {2'b00, w_tl_m};
        w_pm   = r_p3_poly[63] ? (64'd0 - r_p3_poly) : r_p3_poly;
        w_pe   = {32'd0, r_p4_lo} + {r_p4_hi, 32'd0};
        w_pe_s = w_pe >> FRAC_BITS;
        w_t_m  = (w_pe_s > {34'd0, TERM_CAP}) ? TERM_CAP : w_pe_s[61:0];
        w_t    = {2'b00, w_t_m};
        w_ts   = $signed(r_p5_t);
        w_dd   = $signed({32'd0, r_p5_c.d});
        if (w_ts > w_dd) begin
            w_tc = w_dd;
        end else if (w_ts < STEP_FLOOR) begin
            w_tc = STEP_FLOOR;
        end else begin
            w_tc = w_ts;
        end
        w_tc_abs = w_tc[63] ? (64'd0 - w_tc) : w_tc;
    end

    // one quotient bit per stage and lane
    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            for (int i = 0; i < 3; i++) begin
                w_dv_sh[k][i] = {r_dv_rem[k][i], r_dv_num[k][i][QUO_W-1]};
                w_dv_ge[k][i] = w_dv_sh[k][i] >= {1'b0, r_dv_c[k].d};
            end
        end
        for (int i = 0; i < 3; i++) begin
            w_dv_ovf0[i] = {2'b00, r_d0_n[i][63:QUO_W]} >= r_d0_c.d;
        end
    end

    // saturating position update
    always_comb begin
        w_fc    = r_dv_c[QUO_W];
        w_moved = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (w_fc.d == '0) begin
                w_m[i] = '0;
            end else if (r_dv_ovf[QUO_W][i]) begin
                w_m[i] = '1;
            end else begin
                w_m[i] = r_dv_q[QUO_W][i];
            end
            w_mv[i] = (w_fc.w.dneg[i] ^ r_dv_tneg[QUO_W]) ? (36'd0 - {2'b00, w_m[i]})
                                                         : {2'b00, w_m[i]};
            w_s36[i] = {{4{w_fc.w.pos[i][31]}}, w_fc.w.pos[i]} + w_mv[i];
            if (w_s36[i][35] && !(&w_s36[i][35:31])) begin
                w_nv[i] = 32'h8000_0000;
            end else if (!w_s36[i][35] && (|w_s36[i][35:31])) begin
                w_nv[i] = 32'h7FFF_FFFF;
            end else begin
                w_nv[i] = w_s36[i][31:0];
            end
            if (!w_fc.w.in_window) w_nv[i] = w_fc.w.pos[i];
            w_moved = w_moved | (w_nv[i] != w_fc.w.pos[i]);
        end
        n_out.particle_index_out = w_fc.w.idx;
        n_out.new_x              = w_nv[0];
        n_out.new_y              = w_nv[1];
        n_out.new_z              = w_nv[2];
        n_out.moved              = w_moved && w_fc.w.in_window;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v  <= '0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_p4_v  <= 1'b0;
            r_p5_v  <= 1'b0;
            r_p6_v  <= 1'b0;
            r_d0_v  <= 1'b0;
            r_dv_v  <= '0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_sq_v  <= {r_sq_v[SQRT_STEPS-1:0], i_valid};
            r_p1_v  <= r_sq_v[SQRT_STEPS];
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            r_p4_v  <= r_p3_v;
            r_p5_v  <= r_p4_v;
            r_p6_v  <= r_p5_v;
            r_d0_v  <= r_p6_v;
            r_dv_v  <= {r_dv_v[QUO_W-1:0], r_d0_v};
            r_out_v <= r_dv_v[QUO_W];
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // root
            r_sq_w[0]    <= i_work;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_rad[0]  <= i_work.sum;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_sq_w[k+1]    <= r_sq_w[k];
                r_sq_rad[k+1]  <= {r_sq_rad[k][61:0], 2'b00};
                r_sq_rem[k+1]  <= w_sq_ge[k] ? (w_sq_sh[k] - {2'b00, r_sq_root[k], 2'b01})
                                             : w_sq_sh[k];
                r_sq_root[k+1] <= {r_sq_root[k][30:0], w_sq_ge[k]};
            end
            // polynomial
            r_p1_c    <= {r_sq_w[SQRT_STEPS], r_sq_root[SQRT_STEPS]};
            r_p1_ql   <= r_qm * w_d2[31:0];
            r_p1_qh   <= r_qm * w_d2[63:32];
            r_p1_l    <= r_lm * r_sq_root[SQRT_STEPS];
            r_p2_c    <= r_p1_c;
            r_p2_tq   <= r_qneg ? (64'd0 - w_tq) : w_tq;
            r_p2_tl   <= r_lneg ? (64'd0 - w_tl) : w_tl;
            r_p3_c    <= r_p2_c;
            r_p3_poly <= r_p2_tq + r_p2_tl + {{32{i_cfg.const_coeff[31]}}, i_cfg.const_coeff};
            r_p4_c    <= r_p3_c;
            r_p4_pneg <= r_p3_poly[63];
            r_p4_lo   <= w_pm[31:0] * r_p3_c.w.elapsed;
            r_p4_hi   <= w_pm[62:32] * r_p3_c.w.elapsed;
            r_p5_c    <= r_p4_c;
            r_p5_t    <= r_p4_pneg ? (64'd0 - w_t) : w_t;
            r_p6_c    <= r_p5_c;
            r_p6_tneg <= w_tc[63];
            r_p6_tm   <= w_tc_abs[32:0];
            // per-axis products
            r_d0_c    <= r_p6_c;
            r_d0_tneg <= r_p6_tneg;
            for (int i = 0; i < 3; i++) begin
                r_d0_n[i] <= r_p6_c.w.mag[i] * r_p6_tm;
            end
            // divide setup
            r_dv_c[0]    <= r_d0_c;
            r_dv_tneg[0] <= r_d0_tneg;
            r_dv_ovf[0]  <= w_dv_ovf0;
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= {2'b00, r_d0_n[i][63:QUO_W]};
                r_dv_num[0][i] <= r_d0_n[i][QUO_W-1:0];
                r_dv_q[0][i]   <= '0;
            end
            // divide steps
            for (int k = 0; k < QUO_W; k++) begin
                r_dv_c[k+1]    <= r_dv_c[k];
                r_dv_tneg[k+1] <= r_dv_tneg[k];
                r_dv_ovf[k+1]  <= r_dv_ovf[k];
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[k+1][i] <= w_dv_ge[k][i]
                        ? 32'(w_dv_sh[k][i] - {1'b0, r_dv_c[k].d}) : w_dv_sh[k][i][31:0];
                    r_dv_num[k+1][i] <= {r_dv_num[k][i][QUO_W-2:0], 1'b0};
                    r_dv_q[k+1][i]   <= {r_dv_q[k][i][QUO_W-2:0], w_dv_ge[k][i]};
                end
            end
            // output register
            r_out <= n_out;
        end
    end

endmodule

// ===== hw/rtl/particle_attract_repel_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_attract_repel_step
// One attract/repel update per particle in signed fixed point: window test
// on the distance, step polynomial, clamp and saturating move.
// ----------------------------------------------------------------------------
// throughput: one particle per cycle while the output accepts, set by the fully
//   pipelined root and per-axis divide (one bit per stage)
// reset: synchronous, active low; clears all valid state and loads the
//   distance window to its full range and the coefficients to zero
module particle_attract_repel_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    par_cfg_if.sink       i_cfg,
    par_in_if.sink        i_in,
    par_out_if.source     o_out
);
    import par_pkg::*;

    t_cfg  r_cfg;
    t_work w_front_work, w_queue_work;
    logic  w_push, w_full, w_pop, w_empty;

    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_distance <= '0;
            r_cfg.max_distance <= '1;
            r_cfg.quad_coeff   <= '0;
            r_cfg.lin_coeff    <= '0;
            r_cfg.const_coeff  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MIN_DIST: r_cfg.min_distance <= i_cfg.wdata[30:0];
                REG_MAX_DIST: r_cfg.max_distance <= i_cfg.wdata[30:0];
                REG_QUAD:     r_cfg.quad_coeff   <= i_cfg.wdata;
                REG_LIN:      r_cfg.lin_coeff    <= i_cfg.wdata;
                REG_CONST:    r_cfg.const_coeff  <= i_cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    // classify
    par_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (i_in.data),
        .i_cfg   (r_cfg),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_work  (w_front_work)
    );

    // decoupling queue
    par_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_front_work),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_work  (w_queue_work)
    );

    // execute
    par_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_empty),
        .o_pop   (w_pop),
        .i_work  (w_queue_work),
        .i_cfg   (r_cfg),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.data)
    );

endmodule
